>>> src/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants for the Euler circuit checker
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

    localparam int unsigned NODE_IN_W = 8;
    localparam int unsigned IDX_W     = 11;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned WORD_SH   = 5;
    localparam int unsigned CNT_W     = 17;

    localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WORD_SH-1:0]   t_bit_idx;

    typedef struct packed {
        logic     found;
        t_bit_idx idx;
    } t_scan;

endpackage

`default_nettype wire

>>> src/ecc_ram.sv
// ----------------------------------------------------------------------------
// ecc_ram
// Simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_ram #(
    parameter int unsigned W     = 32,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/ecc_lsb_find.sv
// ----------------------------------------------------------------------------
// ecc_lsb_find
// Finds the lowest set bit of one adjacency word
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_lsb_find (
    input  wire ecc_pkg::t_word i_word,
    output ecc_pkg::t_scan      o_scan
);
    import ecc_pkg::*;

    always_comb begin
        o_scan.found = |i_word;
        o_scan.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (i_word[i]) begin
                o_scan.idx = t_bit_idx'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> src/euler_circuit_checker_core.sv
// ----------------------------------------------------------------------------
// euler_circuit_checker_core
// Edge loader and Hierholzer walk over a word-organized adjacency memory
// ----------------------------------------------------------------------------
// An add transfer read-modify-writes the two mirrored adjacency words and the
// two parity entries through the read ports of registered memories. A finish
// transfer runs the walk if no degree is odd, the count is not saturated and
// the start node is in range: each stack top's row is scanned word by word, a
// removed edge also clears its mirrored bit and pushes the neighbour, and a pop
// reloads the top. After the answer a clearing pass over all NODES << WW words
// (2048 for 256 nodes) zeroes the adjacency and parity memories; the same pass
// runs after reset. The input side is stalled for the whole of that work.
`default_nettype none

module euler_circuit_checker_core #(
    parameter int unsigned NODES = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_operation,
    input  wire logic [ecc_pkg::NODE_IN_W-1:0] i_node_a,
    input  wire logic [ecc_pkg::NODE_IN_W-1:0] i_node_b,
    input  wire logic [ecc_pkg::NODE_IN_W-1:0] i_start_node,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_has_circuit,
    output logic                             o_count_saturated
);
    import ecc_pkg::*;

    localparam int unsigned NW          = $clog2(NODES);
    localparam int unsigned WPR         = (NODES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WW          = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int unsigned AW          = NW + WW;
    localparam int unsigned ADEPTH      = NODES << WW;
    localparam int unsigned STACK_DEPTH = (NODES * (NODES + 1)) / 2 + 1;
    localparam int unsigned SAW         = $clog2(STACK_DEPTH);
    localparam int unsigned SPW         = $clog2(STACK_DEPTH + 1);
    localparam int unsigned OW          = $clog2(NODES + 1);

    localparam logic [WW-1:0]    WLAST   = WW'(WPR - 1);
    localparam logic [AW-1:0]    ALAST   = AW'(ADEPTH - 1);
    localparam logic [IDX_W-1:0] NODES_X = IDX_W'(NODES);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_A_RD,
        S_ADD_A_WR,
        S_ADD_B_RD,
        S_ADD_B_WR,
        S_FIN,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CLR_RD,
        S_CLR_WR,
        S_POP_RD,
        S_POP_LD,
        S_CMP,
        S_RESULT
    } t_state;

    function automatic logic [WW-1:0] f_word(input logic [NW-1:0] n);
        logic [IDX_W-1:0] e;
        e = IDX_W'(n);
        return WW'(e >> WORD_SH);
    endfunction

    function automatic t_word f_bit(input logic [NW-1:0] n);
        logic [IDX_W-1:0] e;
        e = IDX_W'(n);
        return t_word'(1) << e[WORD_SH-1:0];
    endfunction

    t_state           r_state, n_state;
    logic [NW-1:0]    r_a, n_a;
    logic [NW-1:0]    r_b, n_b;
    logic [NW-1:0]    r_top, n_top;
    logic [NW-1:0]    r_nb, n_nb;
    logic [WW-1:0]    r_word, n_word;
    logic [SPW-1:0]   r_sp, n_sp;
    logic [CNT_W-1:0] r_edge, n_edge;
    logic [CNT_W-1:0] r_popped, n_popped;
    logic [OW-1:0]    r_odd, n_odd;
    logic [AW-1:0]    r_clr, n_clr;
    logic             r_ok, n_ok;
    logic             r_sat, n_sat;
    logic             r_start_in, n_start_in;
    logic             r_out_valid, n_out_valid;
    logic             r_out_has, n_out_has;
    logic             r_out_sat, n_out_sat;

    logic             adj_we;
    logic [AW-1:0]    adj_waddr, adj_raddr;
    t_word            adj_wdata, adj_rdata;
    logic             par_we;
    logic [NW-1:0]    par_waddr, par_raddr;
    logic             par_wdata, par_rdata;
    logic             stk_we;
    logic [SAW-1:0]   stk_waddr, stk_raddr;
    logic [NW-1:0]    stk_wdata, stk_rdata;
    t_scan            scan;

    logic             accept;
    logic [IDX_W-1:0] a_x, b_x, s_x;

    ecc_ram #(.W(WORD_BITS), .DEPTH(ADEPTH)) u_adj (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    ecc_ram #(.W(1), .DEPTH(NODES)) u_par (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    ecc_ram #(.W(NW), .DEPTH(STACK_DEPTH)) u_stk (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    ecc_lsb_find u_scan (
        .i_word (adj_rdata),
        .o_scan (scan)
    );

    assign a_x    = IDX_W'(i_node_a);
    assign b_x    = IDX_W'(i_node_b);
    assign s_x    = IDX_W'(i_start_node);
    assign accept = i_valid && (r_state == S_IDLE);

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_has_circuit     = r_out_has;
    assign o_count_saturated = r_out_sat;

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_top       = r_top;
        n_nb        = r_nb;
        n_word      = r_word;
        n_sp        = r_sp;
        n_edge      = r_edge;
        n_popped    = r_popped;
        n_odd       = r_odd;
        n_clr       = r_clr;
        n_ok        = r_ok;
        n_sat       = r_sat;
        n_start_in  = r_start_in;
        n_out_valid = r_out_valid && i_stall;
        n_out_has   = r_out_has;
        n_out_sat   = r_out_sat;

        adj_we    = 1'b0;
        adj_waddr = {r_top, r_word};
        adj_wdata = '0;
        adj_raddr = {r_top, r_word};
        par_we    = 1'b0;
        par_waddr = r_a;
        par_wdata = 1'b0;
        par_raddr = r_a;
        stk_we    = 1'b0;
        stk_waddr = SAW'(r_sp);
        stk_wdata = r_nb;
        stk_raddr = SAW'(r_sp - SPW'(1));

        unique case (r_state)
            S_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr;
                adj_wdata = '0;
                par_we    = 1'b1;
                par_waddr = r_clr[AW-1:WW];
                par_wdata = 1'b0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == ALAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_a        = NW'(a_x);
                    n_b        = NW'(b_x);
                    n_top      = NW'(s_x);
                    n_start_in = (s_x < NODES_X);
                    if (t_op'(i_operation) == OP_FINISH) begin
                        n_state = S_FIN;
                    end else if ((a_x < NODES_X) && (b_x < NODES_X)) begin
                        n_state = S_ADD_A_RD;
                    end
                end
            end
            S_ADD_A_RD: begin
                adj_raddr = {r_a, f_word(r_b)};
                par_raddr = r_a;
                n_state   = S_ADD_A_WR;
            end
            S_ADD_A_WR: begin
                adj_we    = 1'b1;
                adj_waddr = {r_a, f_word(r_b)};
                adj_wdata = adj_rdata | f_bit(r_b);
                par_we    = 1'b1;
                par_waddr = r_a;
                par_wdata = ~par_rdata;
                n_odd     = par_rdata ? r_odd - OW'(1) : r_odd + OW'(1);
                if (r_edge != COUNT_MAX) begin
                    n_edge = r_edge + CNT_W'(1);
                end
                n_state = S_ADD_B_RD;
            end
            S_ADD_B_RD: begin
                adj_raddr = {r_b, f_word(r_a)};
                par_raddr = r_b;
                n_state   = S_ADD_B_WR;
            end
            S_ADD_B_WR: begin
                adj_we    = 1'b1;
                adj_waddr = {r_b, f_word(r_a)};
                adj_wdata = adj_rdata | f_bit(r_a);
                par_we    = 1'b1;
                par_waddr = r_b;
                par_wdata = ~par_rdata;
                n_odd     = par_rdata ? r_odd - OW'(1) : r_odd + OW'(1);
                n_state   = S_IDLE;
            end
            S_FIN: begin
                n_sat = (r_edge == COUNT_MAX);
                if ((r_edge == COUNT_MAX) || (r_odd != '0)) begin
                    n_ok    = 1'b0;
                    n_state = S_CMP;
                end else if (r_start_in) begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = r_top;
                    n_sp      = SPW'(1);
                    n_word    = '0;
                    n_popped  = '0;
                    n_ok      = 1'b1;
                    n_state   = S_SCAN_RD;
                end else begin
                    n_popped = CNT_W'(1);
                    n_ok     = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_SCAN_RD: begin
                adj_raddr = {r_top, r_word};
                n_state   = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (scan.found) begin
                    adj_we    = 1'b1;
                    adj_waddr = {r_top, r_word};
                    adj_wdata = adj_rdata & ~(t_word'(1) << scan.idx);
                    n_nb      = NW'({r_word, scan.idx});
                    n_state   = S_CLR_RD;
                end else if (r_word != WLAST) begin
                    n_word  = r_word + WW'(1);
                    n_state = S_SCAN_RD;
                end else begin
                    n_sp = r_sp - SPW'(1);
                    if (r_popped != COUNT_MAX) begin
                        n_popped = r_popped + CNT_W'(1);
                    end
                    n_state = (r_sp == SPW'(1)) ? S_CMP : S_POP_RD;
                end
            end
            S_CLR_RD: begin
                adj_raddr = {r_nb, f_word(r_top)};
                n_state   = S_CLR_WR;
            end
            S_CLR_WR: begin
                adj_we    = 1'b1;
                adj_waddr = {r_nb, f_word(r_top)};
                adj_wdata = adj_rdata & ~f_bit(r_top);
                stk_we    = 1'b1;
                stk_waddr = SAW'(r_sp);
                stk_wdata = r_nb;
                n_sp      = r_sp + SPW'(1);
                n_top     = r_nb;
                n_word    = '0;
                n_state   = S_SCAN_RD;
            end
            S_POP_RD: begin
                stk_raddr = SAW'(r_sp - SPW'(1));
                n_state   = S_POP_LD;
            end
            S_POP_LD: begin
                n_top   = stk_rdata;
                n_word  = '0;
                n_state = S_SCAN_RD;
            end
            S_CMP: begin
                n_ok    = r_ok && ((CNT_W + 1)'(r_popped) == (CNT_W + 1)'(r_edge) + 18'd1);
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_has   = r_ok;
                    n_out_sat   = r_sat;
                    n_edge      = '0;
                    n_odd       = '0;
                    n_clr       = '0;
                    n_state     = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_edge      <= '0;
            r_odd       <= '0;
            r_sp        <= '0;
            r_popped    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_edge      <= n_edge;
            r_odd       <= n_odd;
            r_sp        <= n_sp;
            r_popped    <= n_popped;
            r_out_valid <= n_out_valid;
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_top      <= n_top;
        r_nb       <= n_nb;
        r_word     <= n_word;
        r_ok       <= n_ok;
        r_sat      <= n_sat;
        r_start_in <= n_start_in;
        r_out_has  <= n_out_has;
        r_out_sat  <= n_out_sat;
    end

endmodule

`default_nettype wire

>>> src/ecc_checker.sv
// ----------------------------------------------------------------------------
// ecc_checker
// Port-level checks for the Euler circuit checker
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       i_operation,
    input wire logic [7:0] i_node_a,
    input wire logic [7:0] i_node_b,
    input wire logic [7:0] i_start_node,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_has_circuit,
    input wire logic       o_count_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_has_circuit)
            && $stable(o_count_saturated)))
        else $error("result changed while stalled");

    a_sat_no: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_has_circuit && o_count_saturated))
        else $error("saturated count reported a circuit");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_operation) |=> o_stall)
        else $error("finish transfer not followed by busy");

endmodule

bind euler_circuit_checker_core ecc_checker u_ecc_checker (.*);

`default_nettype wire

>>> test/tb_euler_circuit_checker_core.sv
// ----------------------------------------------------------------------------
// tb_euler_circuit_checker_core
// Self-checking bench for the Euler circuit checker core
// ----------------------------------------------------------------------------
// Graphs are loaded edge by edge, then closed with a finish transfer. A local
// copy of the adjacency matrix, degree parity and edge count predicts each
// answer by running the same stack-based Hierholzer walk. Directed tests
// cover empty graphs, self-loops, repeated edges, odd degrees and
// disconnected parts. Random graphs are mostly closed walks with random
// nodes, mixed with random edge noise. The sender works in bursts and the
// receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_euler_circuit_checker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ecc_pkg::*;

    localparam int NODES       = 256;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int HOLD_CYCLES = 20000;
    localparam int RANDOM_ITEMS = 1650;

    typedef struct {
        t_op        op;
        logic [7:0] na;
        logic [7:0] nb;
        logic [7:0] st;
    } t_item;

    typedef struct {
        logic has_circuit;
        logic saturated;
    } t_answer;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       in_operation;
    logic [7:0] in_node_a;
    logic [7:0] in_node_b;
    logic [7:0] in_start;
    logic       out_valid;
    logic       out_stall;
    logic       out_has_circuit;
    logic       out_saturated;

    euler_circuit_checker_core #(.NODES(NODES)) u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (in_valid),
        .o_stall           (in_stall),
        .i_operation       (in_operation),
        .i_node_a          (in_node_a),
        .i_node_b          (in_node_b),
        .i_start_node      (in_start),
        .o_valid           (out_valid),
        .i_stall           (out_stall),
        .o_has_circuit     (out_has_circuit),
        .o_count_saturated (out_saturated)
    );

    t_item   pending_items[$];
    t_answer expected_answers[$];

    bit [NODES-1:0] adj_row[NODES];
    bit [NODES-1:0] parity;
    int unsigned    edge_total;

    int unsigned errors;
    int unsigned cycles;
    int unsigned answers_seen;
    int unsigned yes_seen;
    int unsigned sat_seen;
    int unsigned adds_sent;

    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_mode_left;
    int unsigned stall_mode;
    logic        hold_off;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch on answer %0d: %s", answers_seen, msg);
        errors++;
    endtask

    function automatic void clear_graph();
        foreach (adj_row[i]) adj_row[i] = '0;
        parity     = '0;
        edge_total = 0;
    endfunction

    function automatic void load_edge(input logic [7:0] a, input logic [7:0] b);
        adj_row[a][b] = 1'b1;
        adj_row[b][a] = 1'b1;
        parity[a]     = ~parity[a];
        parity[b]     = ~parity[b];
        if (edge_total < COUNT_MAX) edge_total++;
    endfunction

    function automatic t_answer predict_circuit(input logic [7:0] st);
        t_answer     ans;
        int          stk[$];
        int unsigned popped;
        int          u;
        int          w;
        bit          ok;
        ans.saturated = (edge_total >= COUNT_MAX);
        ok = !ans.saturated && (parity == '0);
        popped = 0;
        if (ok) begin
            stk.insert(stk.size(), int'(st));
            while (stk.size() > 0) begin
                u = stk[$];
                w = -1;
                for (int k = 0; k < NODES; k++) begin
                    if (adj_row[u][k]) begin
                        w = k;
                        break;
                    end
                end
                if (w >= 0) begin
                    adj_row[u][w] = 1'b0;
                    adj_row[w][u] = 1'b0;
                    stk.insert(stk.size(), w);
                end else begin
                    void'(stk.pop_back());
                    if (popped < COUNT_MAX) popped++;
                end
            end
            if (popped != edge_total + 1) ok = 0;
        end
        ans.has_circuit = ok;
        clear_graph();
        return ans;
    endfunction

    function automatic void queue_add(input int a, input int b);
        t_item it;
        it.op = OP_ADD;
        it.na = a[7:0];
        it.nb = b[7:0];
        it.st = 8'($urandom);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void queue_finish(input int s);
        t_item it;
        it.op = OP_FINISH;
        it.na = 8'($urandom);
        it.nb = 8'($urandom);
        it.st = s[7:0];
        pending_items.insert(pending_items.size(), it);
    endfunction

    // closed walk through random nodes, hub shared by all loops
    function automatic int queue_cycle(input int hub, input int len);
        int prev;
        int nxt;
        prev = hub;
        for (int k = 1; k < len; k++) begin
            nxt = $urandom_range(0, NODES - 1);
            queue_add(prev, nxt);
            prev = nxt;
        end
        queue_add(prev, hub);
        return len;
    endfunction

    initial begin
        int n;
        int hub;
        int kind;
        // empty graph, from lowest and highest start
        queue_finish(0);
        queue_finish(255);
        // triangle
        queue_add(0, 1); queue_add(1, 2); queue_add(2, 0); queue_finish(0);
        // self-loop, walk from its node and from elsewhere
        queue_add(255, 255); queue_finish(255);
        queue_add(5, 5); queue_finish(7);
        // repeated edge
        queue_add(0, 1); queue_add(1, 0); queue_finish(1);
        // odd degree
        queue_add(254, 255); queue_finish(254);
        // two disjoint triangles
        queue_add(10, 11); queue_add(11, 12); queue_add(12, 10);
        queue_add(20, 21); queue_add(21, 22); queue_add(22, 20); queue_finish(10);

        n = 0;
        while (n < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            hub  = $urandom_range(0, NODES - 1);
            if (kind < 7) begin
                repeat ($urandom_range(1, 3)) n += queue_cycle(hub, $urandom_range(1, 10));
                if (kind == 6) begin
                    queue_add($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
                    n++;
                end
                queue_finish(($urandom_range(0, 7) == 0) ? $urandom_range(0, NODES - 1) : hub);
            end else begin
                repeat ($urandom_range(0, 12)) begin
                    queue_add($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
                    n++;
                end
                queue_finish($urandom_range(0, NODES - 1));
            end
            n++;
        end
    end

    initial begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: bursts with gaps, payload held while stalled
    always @(posedge clk) begin
        t_item it;
        if (!rst_n) begin
            in_valid     <= 1'b0;
            in_operation <= OP_ADD;
            in_node_a    <= '0;
            in_node_b    <= '0;
            in_start     <= '0;
            burst_left   <= 1;
            gap_left     <= 0;
            clear_graph();
        end else begin
            if (in_valid && !in_stall) begin
                if (t_op'(in_operation) == OP_ADD) begin
                    load_edge(in_node_a, in_node_b);
                    adds_sent++;
                end else begin
                    expected_answers.insert(expected_answers.size(),
                                            predict_circuit(in_start));
                end
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    in_valid     <= 1'b1;
                    in_operation <= it.op;
                    in_node_a    <= it.na;
                    in_node_b    <= it.nb;
                    in_start     <= it.st;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall       <= 1'b0;
            stall_mode      <= 0;
            stall_mode_left <= 0;
        end else begin
            if (stall_mode_left == 0) begin
                stall_mode      <= $urandom_range(0, 2);
                stall_mode_left <= $urandom_range(50, 3000);
            end else begin
                stall_mode_left <= stall_mode_left - 1;
            end
            case (stall_mode)
                0: out_stall <= hold_off;
                1: out_stall <= hold_off || ($urandom_range(0, 3) == 0);
                default: out_stall <= hold_off || ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // long hold-off while the sender keeps offering items
    initial begin
        hold_off = 1'b0;
        while (answers_seen < 15) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result checker and watchdog
    always @(posedge clk) begin
        t_answer want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected answer transfer");
            end else begin
                want = expected_answers.pop_front();
                if (out_has_circuit !== want.has_circuit)
                    report_mismatch($sformatf("has_circuit got %0b expected %0b",
                                              out_has_circuit, want.has_circuit));
                if (out_saturated !== want.saturated)
                    report_mismatch($sformatf("count_saturated got %0b expected %0b",
                                              out_saturated, want.saturated));
                if (want.has_circuit) yes_seen++;
                if (want.saturated) sat_seen++;
            end
            answers_seen++;
        end
    end

    initial begin
        @(posedge rst_n);
        while (pending_items.size() > 0 || in_valid) @(posedge clk);
        while (expected_answers.size() > 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        if (expected_answers.size() > 0) report_mismatch("answers still outstanding");
        $display("graphs answered: %0d (circuits %0d, saturated %0d), edge transfers: %0d",
                 answers_seen, yes_seen, sat_seen, adds_sent);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
